>>> src/kci_pkg.sv
// Shared types and constants of the keyframe channel interpolator.
package kci_pkg;

  localparam int VAL_W    = 16;
  localparam int TIME_W   = 16;
  localparam int PROD_W   = VAL_W + TIME_W;
  localparam int DIV_STEPS = VAL_W;
  localparam int LATENCY  = 3 + DIV_STEPS + 1;

  typedef enum logic {
    KIND_ROTATION    = 1'b0,
    KIND_TRANSLATION = 1'b1
  } kind_t;

  typedef struct packed {
    logic                    channel_kind;
    logic signed [VAL_W-1:0] old_value;
    logic signed [VAL_W-1:0] new_value;
    logic [TIME_W-1:0]       now_time;
    logic [TIME_W-1:0]       start_time;
    logic [TIME_W-1:0]       key_length;
  } item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    keyframe_done;
  } result_t;

  typedef struct packed {
    logic [VAL_W-1:0] base;
    logic [VAL_W-1:0] new_value;
    logic             neg;
    logic             done;
  } side_t;

endpackage

>>> src/keyframe_channel_interpolator.sv
// Top level of the keyframe channel interpolator.
//
//   channel   direction  handshake             payload
//   item      in         start / busy          kci_pkg::item_t
//   result    out        result_strobe         kci_pkg::result_t
//
// One item per cycle while busy is low; each item passes through, in order:
// three front stages (delta, magnitude, 16x16 product), sixteen divider
// stages of one quotient bit each, one output stage.
// busy is high through reset and for one cycle after it; reset empties the pipeline.
// The receiver takes every result in its strobe cycle, so nothing stalls.
module keyframe_channel_interpolator #(
  parameter int ANGLE_STEPS = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  kci_pkg::item_t    item,
  output logic              result_strobe,
  output kci_pkg::result_t  result
);
  import kci_pkg::*;

  logic              accept;
  logic              prep_valid;
  logic [PROD_W-1:0] product;
  logic [TIME_W-1:0] len;
  side_t             prep_side;
  logic              div_valid;
  logic [VAL_W-1:0]  quotient;
  side_t             div_side;

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  assign accept = start && !busy;

  kci_prep #(
    .ANGLE_STEPS(ANGLE_STEPS)
  ) u_prep (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .item     (item),
    .out_valid(prep_valid),
    .product  (product),
    .len      (len),
    .side     (prep_side)
  );

  kci_div u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (prep_valid),
    .product  (product),
    .len      (len),
    .side_in  (prep_side),
    .out_valid(div_valid),
    .quotient (quotient),
    .side_out (div_side)
  );

  kci_fix u_fix (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (div_valid),
    .quotient     (quotient),
    .side         (div_side),
    .result_strobe(result_strobe),
    .result       (result)
  );

  a_latency_fwd: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY result_strobe)
    else $error("transfer produced no result");

  a_latency_bwd: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(accept, LATENCY))
    else $error("result without matching transfer");

  a_done_value: assert property (@(posedge clk) disable iff (rst)
    result_strobe && result.keyframe_done |->
      result.value == $past(item.new_value, LATENCY))
    else $error("finished keyframe did not pass target value");

endmodule

>>> src/kci_prep.sv
// Front stages: elapsed time, delta (wrapped for rotation channels), magnitude and product.
module kci_prep #(
  parameter int ANGLE_STEPS = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  kci_pkg::item_t                    item,
  output logic                              out_valid,
  output logic [kci_pkg::PROD_W-1:0]        product,
  output logic [kci_pkg::TIME_W-1:0]        len,
  output kci_pkg::side_t                    side
);
  import kci_pkg::*;

  localparam logic [VAL_W-1:0]        STEPS  = VAL_W'(ANGLE_STEPS);
  localparam logic signed [VAL_W:0]   HALF_P = (VAL_W+1)'(ANGLE_STEPS / 2);
  localparam logic signed [VAL_W:0]   HALF_N = -HALF_P;

  logic [TIME_W-1:0]       elapsed;
  logic [VAL_W-1:0]        diff;
  logic signed [VAL_W:0]   diff_x;
  logic [VAL_W-1:0]        base_next;
  logic signed [VAL_W:0]   delta_next;
  logic [VAL_W-1:0]        shifted;

  logic                    a_valid;
  logic signed [VAL_W:0]   a_delta;
  logic [VAL_W-1:0]        a_base;
  logic [VAL_W-1:0]        a_new;
  logic [TIME_W-1:0]       a_elapsed;
  logic [TIME_W-1:0]       a_len;
  logic                    a_done;

  logic                    b_valid;
  logic [VAL_W-1:0]        b_mag;
  logic [TIME_W-1:0]       b_elapsed;
  logic [TIME_W-1:0]       b_len;
  side_t                   b_side;

  logic [VAL_W:0]          neg_delta;

  always_comb begin
    elapsed    = item.now_time - item.start_time;
    diff       = item.new_value - item.old_value;
    diff_x     = {diff[VAL_W-1], diff};
    shifted    = item.old_value + STEPS;
    base_next  = item.old_value;
    delta_next = diff_x;
    if (kind_t'(item.channel_kind) == KIND_TRANSLATION) begin
      delta_next = {item.new_value[VAL_W-1], item.new_value}
                 - {item.old_value[VAL_W-1], item.old_value};
    end else if (diff_x > HALF_P) begin
      base_next  = shifted;
      delta_next = {diff[VAL_W-1] ^ 1'b0, diff} - {1'b0, STEPS};
      delta_next = {delta_next[VAL_W-1], delta_next[VAL_W-1:0]};
    end else if (diff_x < HALF_N) begin
      delta_next = {1'b0, diff + STEPS};
      delta_next = {delta_next[VAL_W-1], delta_next[VAL_W-1:0]};
    end
  end

  assign neg_delta = -a_delta;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      a_valid   <= in_valid;
      b_valid   <= a_valid;
      out_valid <= b_valid;
    end
    a_delta   <= delta_next;
    a_base    <= base_next;
    a_new     <= item.new_value;
    a_elapsed <= elapsed;
    a_len     <= item.key_length;
    a_done    <= (elapsed >= item.key_length);

    b_mag            <= a_delta[VAL_W] ? neg_delta[VAL_W-1:0] : a_delta[VAL_W-1:0];
    b_elapsed        <= a_elapsed;
    b_len            <= a_len;
    b_side.base      <= a_base;
    b_side.new_value <= a_new;
    b_side.neg       <= a_delta[VAL_W];
    b_side.done      <= a_done;

    product <= b_mag * b_elapsed;
    len     <= b_len;
    side    <= b_side;
  end

endmodule

>>> src/kci_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module kci_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [kci_pkg::PROD_W-1:0]   product,
  input  logic [kci_pkg::TIME_W-1:0]   len,
  input  kci_pkg::side_t               side_in,
  output logic                         out_valid,
  output logic [kci_pkg::VAL_W-1:0]    quotient,
  output kci_pkg::side_t               side_out
);
  import kci_pkg::*;

  logic                 valid_q [DIV_STEPS];
  logic [TIME_W-1:0]    rem_q   [DIV_STEPS];
  logic [VAL_W-1:0]     low_q   [DIV_STEPS];
  logic [TIME_W-1:0]    len_q   [DIV_STEPS];
  side_t                side_q  [DIV_STEPS];

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    logic              v_in;
    logic [TIME_W-1:0] r_in;
    logic [VAL_W-1:0]  l_in;
    logic [TIME_W-1:0] d_in;
    side_t             s_in;
    logic [TIME_W:0]   trial;
    logic [TIME_W:0]   diff;
    logic              ge;

    if (i == 0) begin : g_first
      assign v_in = in_valid;
      assign r_in = product[PROD_W-1:VAL_W];
      assign l_in = product[VAL_W-1:0];
      assign d_in = len;
      assign s_in = side_in;
    end else begin : g_next
      assign v_in = valid_q[i-1];
      assign r_in = rem_q[i-1];
      assign l_in = low_q[i-1];
      assign d_in = len_q[i-1];
      assign s_in = side_q[i-1];
    end

    always_comb begin
      trial = {r_in, l_in[VAL_W-1]};
      diff  = trial - {1'b0, d_in};
      ge    = (trial >= {1'b0, d_in});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[i] <= 1'b0;
      end else begin
        valid_q[i] <= v_in;
      end
      rem_q[i]  <= ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
      low_q[i]  <= {l_in[VAL_W-2:0], ge};
      len_q[i]  <= d_in;
      side_q[i] <= s_in;
    end
  end

  assign out_valid = valid_q[DIV_STEPS-1];
  assign quotient  = low_q[DIV_STEPS-1];
  assign side_out  = side_q[DIV_STEPS-1];

endmodule

>>> src/kci_fix.sv
// Output stage: apply sign, add base, select finished keyframes.
module kci_fix (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [kci_pkg::VAL_W-1:0]    quotient,
  input  kci_pkg::side_t               side,
  output logic                         result_strobe,
  output kci_pkg::result_t             result
);
  import kci_pkg::*;

  logic [VAL_W-1:0] step;
  logic [VAL_W-1:0] sum;

  always_comb begin
    step = side.neg ? -quotient : quotient;
    sum  = side.base + step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= in_valid;
    end
    result.value         <= side.done ? side.new_value : sum;
    result.keyframe_done <= side.done;
  end

endmodule

>>> bench/tb_keyframe_channel_interpolator.sv
// Self-checking testbench for the keyframe channel interpolator.
module tb_keyframe_channel_interpolator;
  import kci_pkg::*;

  localparam int ANGLE_STEPS = 1024;
  localparam longint HALF_TURN = ANGLE_STEPS / 2;
  localparam int DRAIN_LIMIT = 4 * LATENCY + 100;
  localparam int RANDOM_PER_PHASE = 600;

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  item_t   item;
  logic    result_strobe;
  result_t result;

  result_t pending_results[$];
  int      error_count = 0;

  keyframe_channel_interpolator #(
    .ANGLE_STEPS(ANGLE_STEPS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .result_strobe(result_strobe),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("** keyframe_channel_interpolator: FAILED **");
    $finish;
  end

  task automatic report_mismatch(string what);
    error_count++;
    $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  function automatic longint wrap_to_16(longint v);
    logic signed [15:0] t;
    t = v[15:0];
    return longint'(t);
  endfunction

  function automatic result_t interpolate_channel(item_t it);
    result_t     r;
    logic [15:0] elapsed;
    longint      oldv, newv, base, delta, span, step, sum;
    elapsed = it.now_time - it.start_time;
    oldv = it.old_value;
    newv = it.new_value;
    base = oldv;
    r.keyframe_done = 1'b0;
    if (elapsed >= it.key_length) begin
      sum = newv;
      r.keyframe_done = 1'b1;
    end else begin
      if (it.channel_kind == KIND_ROTATION) begin
        delta = wrap_to_16(newv - oldv);
        if (delta > HALF_TURN) begin
          base = wrap_to_16(oldv + ANGLE_STEPS);
          delta = wrap_to_16(newv - base);
        end else if (delta < -HALF_TURN) begin
          delta = wrap_to_16(wrap_to_16(newv + ANGLE_STEPS) - oldv);
        end
      end else begin
        delta = newv - oldv;
      end
      step = longint'(elapsed);
      span = longint'(it.key_length);
      sum = (delta * step) / span + base;
    end
    r.value = sum[15:0];
    return r;
  endfunction

  function automatic item_t make_channel(kind_t kind, int oldv, int newv, int now,
                                         int since, int len);
    item_t it;
    it.channel_kind = kind;
    it.old_value    = oldv[15:0];
    it.new_value    = newv[15:0];
    it.now_time     = now[15:0];
    it.start_time   = since[15:0];
    it.key_length   = len[15:0];
    return it;
  endfunction

  function automatic int pick_extreme();
    case ($urandom_range(6))
      0: return -32768;
      1: return -32767;
      2: return -1;
      3: return 0;
      4: return 1;
      5: return 32766;
      default: return 32767;
    endcase
  endfunction

  function automatic item_t random_channel();
    item_t it;
    int    oldv, newv, len, elapsed, since;
    oldv = int'($urandom_range(65535)) - 32768;
    case ($urandom_range(9))
      0, 1: newv = int'($urandom_range(65535)) - 32768;
      2, 3, 4: newv = oldv + int'($urandom_range(3200)) - 1600;
      5: newv = oldv + ($urandom_range(1) ? 1 : -1) * int'($urandom_range(510, 514));
      6: newv = oldv;
      7: begin
        oldv = 0;
        newv = int'($urandom_range(65535)) - 32768;
      end
      default: begin
        oldv = pick_extreme();
        newv = pick_extreme();
      end
    endcase
    case ($urandom_range(7))
      0, 1, 2: len = $urandom_range(1, 20);
      3: len = $urandom_range(0, 1);
      4: len = 65535;
      default: len = $urandom_range(65535);
    endcase
    if (len > 0 && $urandom_range(99) < 85) elapsed = $urandom_range(len - 1);
    else elapsed = $urandom_range(65535);
    since = $urandom_range(65535);
    it = make_channel($urandom_range(1) ? KIND_TRANSLATION : KIND_ROTATION, oldv, newv,
                      since + elapsed, since, len);
    return it;
  endfunction

  // Hold start high until the transfer completes; the caller lowers it or sends on.
  task automatic send_channel(item_t it);
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(interpolate_channel(it));
  endtask

  task automatic idle_sender(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_for_results();
    int waited;
    waited = 0;
    start <= 1'b0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
      pending_results.delete();
    end
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_strobe === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result value=%0d done=%0b",
                                  result.value, result.keyframe_done));
      end else begin
        want = pending_results.pop_front();
        if (result.value !== want.value)
          report_mismatch($sformatf("value got %0d want %0d", result.value, want.value));
        if (result.keyframe_done !== want.keyframe_done)
          report_mismatch($sformatf("keyframe_done got %0b want %0b",
                                    result.keyframe_done, want.keyframe_done));
      end
    end
  end

  task automatic test_directed_channels();
    send_channel(make_channel(KIND_ROTATION, 100, 200, 5, 5, 0));
    send_channel(make_channel(KIND_TRANSLATION, -50, 70, 110, 10, 100));
    send_channel(make_channel(KIND_TRANSLATION, -1000, 1000, 5, 65530, 20));
    send_channel(make_channel(KIND_TRANSLATION, 3, 9, 0, 1, 65535));
    send_channel(make_channel(KIND_TRANSLATION, -32768, 32767, 65534, 0, 65535));
    send_channel(make_channel(KIND_TRANSLATION, 32767, -32768, 1, 0, 3));
    send_channel(make_channel(KIND_ROTATION, 300, 300, 1, 0, 2));
    send_channel(make_channel(KIND_TRANSLATION, -5, -5, 7, 3, 9));
    send_channel(make_channel(KIND_ROTATION, 0, 512, 1, 0, 2));
    send_channel(make_channel(KIND_ROTATION, 0, 513, 1, 0, 2));
    send_channel(make_channel(KIND_ROTATION, 512, 0, 1, 0, 2));
    send_channel(make_channel(KIND_ROTATION, 513, 0, 1, 0, 2));
    send_channel(make_channel(KIND_ROTATION, 0, 1024, 3, 0, 7));
    send_channel(make_channel(KIND_ROTATION, 32000, -32000, 5, 0, 11));
    send_channel(make_channel(KIND_ROTATION, -600, 32767, 2, 0, 9));
    send_channel(make_channel(KIND_ROTATION, 32767, -32768, 1, 0, 4));
    send_channel(make_channel(KIND_TRANSLATION, 0, 32767, 12345, 0, 40000));
    send_channel(make_channel(KIND_TRANSLATION, 0, -32768, 1, 0, 65535));
    send_channel(make_channel(KIND_TRANSLATION, 0, -7, 1, 0, 2));
    send_channel(make_channel(KIND_ROTATION, 10, 20, 0, 0, 1));
    send_channel(make_channel(KIND_ROTATION, -32768, -32768, 65535, 0, 65535));
    send_channel(make_channel(KIND_TRANSLATION, 32767, 32767, 65535, 65535, 0));
    wait_for_results();
  endtask

  // Every fourth block of forty transfers runs without idle gaps, but for the midway pause.
  task automatic run_random_channels(int count, int idle_pct, bit pause_midway);
    int pct;
    for (int i = 0; i < count; i++) begin
      send_channel(random_channel());
      pct = (((i / 40) % 4) == 3) ? 0 : idle_pct;
      if (pause_midway && i == count / 2) wait_for_results();
      else if ($urandom_range(99) < pct) idle_sender($urandom_range(1, 6));
    end
    wait_for_results();
  endtask

  task automatic test_back_to_back();
    run_random_channels(RANDOM_PER_PHASE, 0, 1'b0);
  endtask

  task automatic test_sender_gaps();
    run_random_channels(RANDOM_PER_PHASE, 45, 1'b1);
  endtask

  task automatic test_sparse_gaps();
    run_random_channels(RANDOM_PER_PHASE, 6, 1'b0);
  endtask

  initial begin
    rst   <= 1'b1;
    start <= 1'b0;
    item  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_channels();
    test_back_to_back();
    test_sender_gaps();
    test_sparse_gaps();
    if (error_count == 0) begin
      $display("** keyframe_channel_interpolator: PASSED **");
    end else begin
      $display("** keyframe_channel_interpolator: FAILED **");
    end
    $finish;
  end

endmodule
